@@ design/abr_pkg.sv @@
// Shared constants and types for the alternating-bit receiver.
package abr_pkg;

	localparam int PAYLOAD_BYTES = 20;
	localparam int POS_W         = 5;
	localparam int RESP_SUM_W    = 6;

	localparam logic [POS_W-1:0] LAST_POS   = POS_W'(PAYLOAD_BYTES - 1);
	localparam logic [31:0]      ACK_WEIGHT = 32'd21;
	localparam logic [31:0]      SEQ_WEIGHT = 32'd22;

	// request held in the input register; header already folded into sum_rem
	typedef struct packed {
		logic [7:0]  data;
		logic        seq_bit;
		logic        seq_ok;
		logic [31:0] sum_rem;
	} item_t;

	typedef struct packed {
		logic [7:0]            out_byte;
		logic                  packet_done;
		logic                  commit;
		logic                  resp_ack;
		logic                  resp_seq;
		logic [RESP_SUM_W-1:0] resp_sum;
	} result_t;

endpackage

@@ design/abr_in_reg.sv @@
// Input register: captures a request and pre-folds the header weights.
module abr_in_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  logic [7:0]          payload_byte,
	input  logic signed [31:0]  pkt_seq,
	input  logic signed [31:0]  pkt_ack,
	input  logic signed [31:0]  pkt_sum,
	input  logic                take_ok,
	output logic                valid_s1,
	output abr_pkg::item_t      item_s1
);

	logic           accept;
	logic           fire;
	abr_pkg::item_t item_d;

	assign fire       = valid_s1 && take_ok;
	assign item_stall = valid_s1 && !take_ok;
	assign accept     = item_valid && !item_stall;

	// checksum test becomes acc == sum - ack*21 - seq*22 downstream
	always_comb begin
		item_d.data    = payload_byte;
		item_d.seq_bit = pkt_seq[0];
		item_d.seq_ok  = (pkt_seq[31:1] == 31'd0);
		item_d.sum_rem = 32'(pkt_sum) - 32'(pkt_ack * abr_pkg::ACK_WEIGHT)
			- 32'(pkt_seq * abr_pkg::SEQ_WEIGHT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

endmodule

@@ design/abr_proc.sv @@
// Packet state and per-byte checksum, zero-fill and response logic.
module abr_proc (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  abr_pkg::item_t   item_s1,
	output abr_pkg::result_t result
);

	logic [abr_pkg::POS_W-1:0] byte_pos_q;
	logic [31:0]               run_sum_q;
	logic                      zero_seen_q;
	logic                      expected_seq_q;

	logic signed [13:0] prod;
	logic [31:0]        acc;
	logic               zs;
	logic               last;
	logic               good;
	logic               take;

	always_comb begin
		prod = $signed(item_s1.data) * $signed({1'b0, byte_pos_q});
		acc  = run_sum_q + {{18{prod[13]}}, prod};
		zs   = zero_seen_q || (item_s1.data == 8'd0);
		last = (byte_pos_q >= abr_pkg::LAST_POS);
		good = (acc == item_s1.sum_rem);
		take = good && item_s1.seq_ok && (item_s1.seq_bit == expected_seq_q);
	end

	always_comb begin
		result.out_byte    = zs ? 8'd0 : item_s1.data;
		result.packet_done = last;
		result.commit      = last && take;
		result.resp_ack    = last && good;
		result.resp_seq    = last && expected_seq_q;
		result.resp_sum    =
			({abr_pkg::RESP_SUM_W{last && good}}
				& abr_pkg::RESP_SUM_W'(abr_pkg::ACK_WEIGHT))
			+ ({abr_pkg::RESP_SUM_W{last && expected_seq_q}}
				& abr_pkg::RESP_SUM_W'(abr_pkg::SEQ_WEIGHT));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q     <= '0;
			run_sum_q      <= '0;
			zero_seen_q    <= 1'b0;
			expected_seq_q <= 1'b0;
		end else if (fire) begin
			if (last) begin
				byte_pos_q  <= '0;
				run_sum_q   <= '0;
				zero_seen_q <= 1'b0;
				if (take) begin
					expected_seq_q <= !expected_seq_q;
				end
			end else begin
				byte_pos_q  <= byte_pos_q + 1'b1;
				run_sum_q   <= acc;
				zero_seen_q <= zs;
			end
		end
	end

endmodule

@@ design/abr_out_reg.sv @@
// Result register towards the consumer.
module abr_out_reg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  abr_pkg::result_t              result,
	output logic                          take_ok,
	output logic                          res_valid,
	input  logic                          res_stall,
	output logic [7:0]                    out_byte,
	output logic                          packet_done,
	output logic                          commit,
	output logic                          resp_ack,
	output logic                          resp_seq,
	output logic [abr_pkg::RESP_SUM_W-1:0] resp_sum
);

	logic             res_valid_q;
	abr_pkg::result_t res_q;

	assign take_ok = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take_ok) begin
			res_valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= result;
		end
	end

	assign res_valid   = res_valid_q;
	assign out_byte    = res_q.out_byte;
	assign packet_done = res_q.packet_done;
	assign commit      = res_q.commit;
	assign resp_ack    = res_q.resp_ack;
	assign resp_seq    = res_q.resp_seq;
	assign resp_sum    = res_q.resp_sum;

endmodule

@@ design/alt_bit_receiver_top.sv @@
// Alternating-bit receiver: one payload byte in, one delivered byte out.
// A request is held in the input register and its result in the output register.
// Throughput: one request per cycle unless stalled; the packet state updates in one pass.
// Stall from the consumer reaches item_stall only when the input register is full.
// Reset (arst_n low, asynchronous): byte index, checksum, zero flag and the
// expected sequence bit clear; both pipeline registers read empty.
module alt_bit_receiver_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic [7:0]                     payload_byte,
	input  logic signed [31:0]             pkt_seq,
	input  logic signed [31:0]             pkt_ack,
	input  logic signed [31:0]             pkt_sum,
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic [7:0]                     out_byte,
	output logic                           packet_done,
	output logic                           commit,
	output logic                           resp_ack,
	output logic                           resp_seq,
	output logic [abr_pkg::RESP_SUM_W-1:0] resp_sum
);

	logic             take_ok;
	logic             valid_s1;
	logic             fire;
	abr_pkg::item_t   item_s1;
	abr_pkg::result_t result;

	assign fire = valid_s1 && take_ok;

	abr_in_reg u_in (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.payload_byte (payload_byte),
		.pkt_seq      (pkt_seq),
		.pkt_ack      (pkt_ack),
		.pkt_sum      (pkt_sum),
		.take_ok      (take_ok),
		.valid_s1     (valid_s1),
		.item_s1      (item_s1)
	);

	abr_proc u_proc (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item_s1 (item_s1),
		.result  (result)
	);

	abr_out_reg u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.result      (result),
		.take_ok     (take_ok),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.out_byte    (out_byte),
		.packet_done (packet_done),
		.commit      (commit),
		.resp_ack    (resp_ack),
		.resp_seq    (resp_seq),
		.resp_sum    (resp_sum)
	);

`ifndef SYNTHESIS
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_commit_needs_ack: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && commit |-> packet_done && resp_ack)
		else $error("commit without an acknowledged final byte");

	a_mid_packet_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !packet_done |-> !commit && !resp_ack && !resp_seq
			&& resp_sum == '0)
		else $error("response fields set on a non-final byte");

	a_resp_sum_match: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && packet_done |-> resp_sum ==
			(abr_pkg::RESP_SUM_W'(resp_ack ? abr_pkg::ACK_WEIGHT : 32'd0)
			+ abr_pkg::RESP_SUM_W'(resp_seq ? abr_pkg::SEQ_WEIGHT : 32'd0)))
		else $error("response checksum does not match kind and sequence");
`endif

endmodule
